// ===== hdl/cbc_pkg.sv =====
package cbc_pkg;

  localparam int ROM_ADDR_BITS_DEF = 21;
  localparam int RAM_ADDR_BITS_DEF = 15;
  localparam int MAP_W             = 21;

  // Controller type codes; the unused code behaves as no controller.
  typedef enum logic [1:0] {
    CTRL_NONE = 2'd0,
    CTRL_MBC1 = 2'd1,
    CTRL_MBC2 = 2'd2
  } ctrl_type_t;

  typedef enum logic [1:0] {
    REGION_ROM   = 2'd0,
    REGION_RAM   = 2'd1,
    REGION_OTHER = 2'd2,
    REGION_REGW  = 2'd3
  } region_t;

  // Bank register select, taken from address bits 14:13 of a write below 0x8000.
  typedef enum logic [1:0] {
    SEL_RAM_EN   = 2'd0,
    SEL_ROM_BANK = 2'd1,
    SEL_UPPER    = 2'd2,
    SEL_MODE     = 2'd3
  } reg_sel_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       region;
    logic [MAP_W-1:0] mapped_address;
    logic             ram_write_enable;
  } out_item_t;

  typedef struct packed {
    logic [4:0] rom_bank_low;
    logic [1:0] bank_upper_bits;
    logic       banking_mode;
    logic       ram_enabled;
  } bank_state_t;

  typedef struct packed {
    logic       en;
    reg_sel_t   sel;
    logic [7:0] data;
  } reg_wr_t;

endpackage

// ===== hdl/cbc_bank_regs.sv =====
module cbc_bank_regs
  import cbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  ctrl_type,
  input  reg_wr_t     reg_wr,
  output bank_state_t state
);

  bank_state_t state_r;
  bank_state_t state_nxt;
  logic        ram_en_hit;
  logic [4:0]  mbc1_bank;
  logic [4:0]  mbc2_bank;

  assign ram_en_hit = (reg_wr.data[3:0] == 4'hA);
  // A zero written to the low bank register selects bank one instead.
  assign mbc1_bank  = (reg_wr.data[4:0] == 5'd0) ? 5'd1 : reg_wr.data[4:0];
  assign mbc2_bank  = (reg_wr.data[3:0] == 4'd0) ? 5'd1 : {1'b0, reg_wr.data[3:0]};

  always_comb begin
    state_nxt = state_r;
    if (reg_wr.en) begin
      case (ctrl_type)
        CTRL_MBC1: begin
          unique case (reg_wr.sel)
            SEL_RAM_EN:   state_nxt.ram_enabled     = ram_en_hit;
            SEL_ROM_BANK: state_nxt.rom_bank_low    = mbc1_bank;
            SEL_UPPER:    state_nxt.bank_upper_bits = reg_wr.data[1:0];
            SEL_MODE:     state_nxt.banking_mode    = reg_wr.data[0];
            default:      state_nxt = state_r;
          endcase
        end
        CTRL_MBC2: begin
          unique case (reg_wr.sel)
            SEL_RAM_EN: begin
              // MBC2 ignores enable writes that carry data bit 4.
              if (!reg_wr.data[4]) begin
                state_nxt.ram_enabled = ram_en_hit;
              end
            end
            SEL_ROM_BANK:        state_nxt.rom_bank_low = mbc2_bank;
            SEL_UPPER, SEL_MODE: state_nxt = state_r;
            default:             state_nxt = state_r;
          endcase
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{rom_bank_low: 5'd1, bank_upper_bits: 2'd0,
                   banking_mode: 1'b0, ram_enabled: 1'b0};
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

  a_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.rom_bank_low != 5'd0)
    else $error("low ROM bank register holds zero");

  a_none_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (reg_wr.en && ctrl_type != CTRL_MBC1 && ctrl_type != CTRL_MBC2) |=> $stable(state_r))
    else $error("bank registers changed without a controller");

  a_mbc2_upper_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_type == CTRL_MBC2) |=> $stable(state_r.bank_upper_bits)
                                 && $stable(state_r.banking_mode))
    else $error("MBC2 changed upper bits or banking mode");

endmodule

// ===== hdl/cbc_xlate.sv =====
module cbc_xlate
  import cbc_pkg::*;
#(
  parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
  parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
)
(
  input  in_item_t    item,
  input  logic [1:0]  ctrl_type,
  input  bank_state_t state,
  output out_item_t   result,
  output reg_wr_t     reg_wr
);

  localparam int              ROM_KEEP = (ROM_ADDR_BITS < MAP_W) ? ROM_ADDR_BITS : MAP_W;
  localparam int              RAM_KEEP = (RAM_ADDR_BITS < MAP_W) ? RAM_ADDR_BITS : MAP_W;
  localparam logic [MAP_W-1:0] ONES     = '1;
  localparam logic [MAP_W-1:0] ROM_MASK = ~(ONES << ROM_KEEP);
  localparam logic [MAP_W-1:0] RAM_MASK = ~(ONES << RAM_KEEP);

  logic             is_cart;
  logic             is_ram;
  logic             upper_half;
  logic [6:0]       rom_bank;
  logic [1:0]       ram_bank;
  logic [MAP_W-1:0] rom_addr;
  logic [MAP_W-1:0] ram_addr;
  logic [MAP_W-1:0] bus_addr;

  assign is_cart    = ~item.address[15];
  assign is_ram     = (item.address[15:13] == 3'b101);
  assign upper_half = item.address[14];
  assign bus_addr   = {{(MAP_W-16){1'b0}}, item.address};

  always_comb begin
    case (ctrl_type)
      CTRL_MBC1: begin
        if (upper_half) begin
          rom_bank = {state.bank_upper_bits, state.rom_bank_low};
        end else if (state.banking_mode) begin
          rom_bank = {state.bank_upper_bits, 5'd0};
        end else begin
          rom_bank = 7'd0;
        end
      end
      CTRL_MBC2: rom_bank = upper_half ? {2'b00, state.rom_bank_low} : 7'd0;
      default:   rom_bank = upper_half ? 7'd1 : 7'd0;
    endcase
  end

  assign ram_bank = (ctrl_type == CTRL_MBC1 && state.banking_mode) ?
                    state.bank_upper_bits : 2'd0;
  assign rom_addr = {rom_bank, item.address[13:0]} & ROM_MASK;
  assign ram_addr = {6'd0, ram_bank, item.address[12:0]} & RAM_MASK;

  always_comb begin
    result.ram_write_enable = 1'b0;
    if (is_cart && item.kind) begin
      result.region         = REGION_REGW;
      result.mapped_address = bus_addr;
    end else if (is_cart) begin
      result.region         = REGION_ROM;
      result.mapped_address = rom_addr;
    end else if (is_ram) begin
      result.region           = REGION_RAM;
      result.mapped_address   = ram_addr;
      result.ram_write_enable = item.kind & state.ram_enabled;
    end else begin
      result.region         = REGION_OTHER;
      result.mapped_address = bus_addr;
    end
  end

  assign reg_wr.en   = is_cart & item.kind;
  assign reg_wr.sel  = reg_sel_t'(item.address[14:13]);
  assign reg_wr.data = item.write_data;

endmodule

// ===== hdl/cartridge_bank_controller.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_item: kind, address, write_data
// out_      output     out_valid/out_stall out_item: region, mapped_address,
//                                          ram_write_enable
// cfg_      input      cfg_we             cfg_wdata: controller_type
//
// One item per cycle while the result register is not stalled; an accepted item
// goes into the input register, then into the result register, and leaves from it.
// The bank registers update as an item leaves the input register, so the next
// item already sees them.
// Synchronous active-low reset empties both stages and restores the bank registers.
// A stalled result register holds the item in the input register and raises in_stall.
module cartridge_bank_controller
  import cbc_pkg::*;
#(
  parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
  parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  logic [1:0]  ctrl_r;
  logic [1:0]  ctrl_nxt;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_item_r;
  logic        out_ready;
  logic        s1_move;
  logic        in_take;
  out_item_t   result;
  reg_wr_t     reg_wr_raw;
  reg_wr_t     reg_wr;
  bank_state_t state;

  assign out_ready = ~out_valid_r | ~out_stall;
  assign s1_move   = s1_valid_r & out_ready;
  assign in_stall  = s1_valid_r & ~out_ready;
  assign in_take   = in_valid & ~in_stall;

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_move);
  assign out_valid_nxt = s1_move | (out_valid_r & out_stall);
  assign ctrl_nxt      = cfg_we ? cfg_wdata : ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= CTRL_NONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ctrl_r      <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_move) begin
      out_item_r <= result;
    end
  end

  cbc_xlate #(
    .ROM_ADDR_BITS(ROM_ADDR_BITS),
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) u_xlate (
    .item      (s1_item_r),
    .ctrl_type (ctrl_r),
    .state     (state),
    .result    (result),
    .reg_wr    (reg_wr_raw)
  );

  // Bank registers change only when the write item actually moves on.
  always_comb begin
    reg_wr    = reg_wr_raw;
    reg_wr.en = reg_wr_raw.en & s1_move;
  end

  cbc_bank_regs u_bank_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_type (ctrl_r),
    .reg_wr    (reg_wr),
    .state     (state)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_wen_only_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.ram_write_enable) |-> out_item_r.region == REGION_RAM)
    else $error("RAM write enable outside external RAM");

  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled item left the input register");

  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_item_r))
    else $error("stalled result changed or was dropped");

endmodule
